// ----- sv/sbd_pkg.sv -----
`timescale 1ns / 1ps
// sbd_pkg: shared types and constants for the spectral beat detector.
// Depends on nothing; used by every module of the block except sbd_div.
package sbd_pkg;

	localparam int unsigned HISTORY_DEPTH_DEF = 64;
	localparam int unsigned FFT_BINS_DEF      = 512;
	localparam int unsigned MAX_CHANNELS_DEF  = 8;

	localparam int unsigned APB_AW = 5;
	localparam int unsigned APB_DW = 32;

	localparam int unsigned SUMW = 29;
	localparam int unsigned BINW = 13;
	localparam int unsigned DVW  = 14;

	localparam logic [SUMW-1:0]   SUM_MAX  = '1;
	localparam logic signed [21:0] THR_BASE = 22'sd101581;
	localparam logic signed [21:0] THR_MIN  = -22'sd1048576;

	typedef enum logic [2:0] {
		REG_BASS_LO  = 3'd0,
		REG_BASS_HI  = 3'd1,
		REG_MID_LO   = 3'd2,
		REG_MID_HI   = 3'd3,
		REG_HIST_LEN = 3'd4,
		REG_CHAN     = 3'd5,
		REG_BASS_OFF = 3'd6,
		REG_MID_OFF  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [8:0]  bass_lo;
		logic [9:0]  bass_hi;
		logic [8:0]  mid_lo;
		logic [9:0]  mid_hi;
		logic [6:0]  hist_len;
		logic [3:0]  chan;
		logic [15:0] bass_off;
		logic [15:0] mid_off;
	} cfg_t;

	typedef enum logic [2:0] {
		DIV_EB = 3'd0,
		DIV_EM = 3'd1,
		DIV_MB = 3'd2,
		DIV_MM = 3'd3,
		DIV_VB = 3'd4,
		DIV_VM = 3'd5
	} div_sel_t;

	typedef struct packed {
		logic     div_start;
		div_sel_t div_sel;
		logic     walk_start;
		logic     walk_var;
		logic     thr_en;
		logic     mul_en;
		logic     push;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic walk_done;
		logic hist_empty;
		logic out_free;
	} stat_t;

endpackage

// ----- sv/sbd_regs.sv -----
`timescale 1ns / 1ps
// sbd_regs: APB configuration registers of the beat detector.
// Depends on sbd_pkg.
module sbd_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sbd_pkg::APB_AW-1:0]    paddr,
	input  logic [sbd_pkg::APB_DW-1:0]    pwdata,
	output logic [sbd_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	output sbd_pkg::cfg_t                 cfg
);

	sbd_pkg::cfg_t     cfg_q;
	sbd_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = sbd_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bass_lo  <= 9'd1;
			cfg_q.bass_hi  <= 10'd3;
			cfg_q.mid_lo   <= 9'd7;
			cfg_q.mid_hi   <= 10'd17;
			cfg_q.hist_len <= 7'd43;
			cfg_q.chan     <= 4'd2;
			cfg_q.bass_off <= 16'd3277;
			cfg_q.mid_off  <= 16'd328;
		end else if (wr_en) begin
			case (idx)
				sbd_pkg::REG_BASS_LO:  cfg_q.bass_lo  <= pwdata[8:0];
				sbd_pkg::REG_BASS_HI:  cfg_q.bass_hi  <= pwdata[9:0];
				sbd_pkg::REG_MID_LO:   cfg_q.mid_lo   <= pwdata[8:0];
				sbd_pkg::REG_MID_HI:   cfg_q.mid_hi   <= pwdata[9:0];
				sbd_pkg::REG_HIST_LEN: cfg_q.hist_len <= pwdata[6:0];
				sbd_pkg::REG_CHAN:     cfg_q.chan     <= pwdata[3:0];
				sbd_pkg::REG_BASS_OFF: cfg_q.bass_off <= pwdata[15:0];
				sbd_pkg::REG_MID_OFF:  cfg_q.mid_off  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			sbd_pkg::REG_BASS_LO:  prdata = 32'(cfg_q.bass_lo);
			sbd_pkg::REG_BASS_HI:  prdata = 32'(cfg_q.bass_hi);
			sbd_pkg::REG_MID_LO:   prdata = 32'(cfg_q.mid_lo);
			sbd_pkg::REG_MID_HI:   prdata = 32'(cfg_q.mid_hi);
			sbd_pkg::REG_HIST_LEN: prdata = 32'(cfg_q.hist_len);
			sbd_pkg::REG_CHAN:     prdata = 32'(cfg_q.chan);
			sbd_pkg::REG_BASS_OFF: prdata = 32'(cfg_q.bass_off);
			sbd_pkg::REG_MID_OFF:  prdata = 32'(cfg_q.mid_off);
			default:               prdata = '0;
		endcase
	end

endmodule

// ----- sv/sbd_div.sv -----
`timescale 1ns / 1ps
// sbd_div: serial restoring divider, one quotient bit per cycle.
// Depends on nothing; shared by all frame-end divisions.
module sbd_div #(
	parameter int unsigned DVD_W = 40,
	parameter int unsigned DVS_W = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int unsigned CW = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             ge;
	logic [DVS_W:0]   diff;

	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- sv/sbd_ctrl.sv -----
`timescale 1ns / 1ps
// sbd_ctrl: sequencer for band accumulation and the frame-end statistics.
// Depends on sbd_pkg.
module sbd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_accept,
	input  logic           frame_last,
	input  sbd_pkg::stat_t st,
	output sbd_pkg::cmd_t  cmd,
	output logic           in_ready
);

	typedef enum logic [3:0] {
		S_IDLE, S_DIV_EB, S_DIV_EM, S_SUMW, S_DIV_MB, S_DIV_MM, S_VARW,
		S_DIV_VB, S_DIV_VM, S_THR, S_MUL, S_WAIT, S_PUSH
	} state_t;

	state_t        state_q;
	sbd_pkg::cmd_t cmd_q;
	logic          rdy_q;

	assign cmd      = cmd_q;
	assign in_ready = rdy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rdy_q   <= 1'b1;
			cmd_q   <= '0;
		end else begin
			cmd_q.div_start  <= 1'b0;
			cmd_q.walk_start <= 1'b0;
			cmd_q.thr_en     <= 1'b0;
			cmd_q.mul_en     <= 1'b0;
			cmd_q.push       <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_accept && frame_last) begin
						state_q         <= S_DIV_EB;
						rdy_q           <= 1'b0;
						cmd_q.div_start <= 1'b1;
						cmd_q.div_sel   <= sbd_pkg::DIV_EB;
					end
				end
				S_DIV_EB: begin
					if (st.div_done) begin
						state_q         <= S_DIV_EM;
						cmd_q.div_start <= 1'b1;
						cmd_q.div_sel   <= sbd_pkg::DIV_EM;
					end
				end
				S_DIV_EM: begin
					if (st.div_done) begin
						if (st.hist_empty) begin
							state_q <= S_WAIT;
						end else begin
							state_q          <= S_SUMW;
							cmd_q.walk_start <= 1'b1;
							cmd_q.walk_var   <= 1'b0;
						end
					end
				end
				S_SUMW: begin
					if (st.walk_done) begin
						state_q         <= S_DIV_MB;
						cmd_q.div_start <= 1'b1;
						cmd_q.div_sel   <= sbd_pkg::DIV_MB;
					end
				end
				S_DIV_MB: begin
					if (st.div_done) begin
						state_q         <= S_DIV_MM;
						cmd_q.div_start <= 1'b1;
						cmd_q.div_sel   <= sbd_pkg::DIV_MM;
					end
				end
				S_DIV_MM: begin
					if (st.div_done) begin
						state_q          <= S_VARW;
						cmd_q.walk_start <= 1'b1;
						cmd_q.walk_var   <= 1'b1;
					end
				end
				S_VARW: begin
					if (st.walk_done) begin
						state_q         <= S_DIV_VB;
						cmd_q.div_start <= 1'b1;
						cmd_q.div_sel   <= sbd_pkg::DIV_VB;
					end
				end
				S_DIV_VB: begin
					if (st.div_done) begin
						state_q         <= S_DIV_VM;
						cmd_q.div_start <= 1'b1;
						cmd_q.div_sel   <= sbd_pkg::DIV_VM;
					end
				end
				S_DIV_VM: begin
					if (st.div_done) begin
						state_q      <= S_THR;
						cmd_q.thr_en <= 1'b1;
					end
				end
				S_THR: begin
					state_q      <= S_MUL;
					cmd_q.mul_en <= 1'b1;
				end
				S_MUL: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (st.out_free) begin
						state_q    <= S_PUSH;
						cmd_q.push <= 1'b1;
					end
				end
				S_PUSH: begin
					state_q <= S_IDLE;
					rdy_q   <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					rdy_q   <= 1'b1;
				end
			endcase
		end
	end

endmodule

// ----- sv/sbd_dp.sv -----
`timescale 1ns / 1ps
// sbd_dp: band sums, history memory, statistics walk and beat compare.
// Depends on sbd_pkg and sbd_div.
module sbd_dp #(
	parameter int unsigned HISTORY_DEPTH = sbd_pkg::HISTORY_DEPTH_DEF,
	parameter int unsigned FFT_BINS      = sbd_pkg::FFT_BINS_DEF,
	parameter int unsigned MAX_CHANNELS  = sbd_pkg::MAX_CHANNELS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sbd_pkg::cfg_t  cfg,
	input  sbd_pkg::cmd_t  cmd,
	output sbd_pkg::stat_t st,
	input  logic           in_accept,
	input  logic [8:0]     bin_index,
	input  logic [15:0]    magnitude,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           bass_beat,
	output logic           mid_beat,
	output logic [15:0]    bass_energy,
	output logic [15:0]    mid_energy,
	output logic [15:0]    bass_average,
	output logic [15:0]    mid_average,
	output logic [6:0]     history_used
);

	localparam int unsigned PW   = $clog2(HISTORY_DEPTH);
	localparam int unsigned CNTW = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned HW   = CNTW + 1;
	localparam int unsigned ACW  = 16 + CNTW;
	localparam int unsigned SQW  = 32 + CNTW;
	localparam int unsigned DVDW = SQW;
	localparam int unsigned BINW = sbd_pkg::BINW;
	localparam int unsigned DVW  = sbd_pkg::DVW;
	localparam int unsigned SUMW = sbd_pkg::SUMW;

	// band setup
	logic [BINW-1:0] bass_eff, mid_eff;
	logic            bass_empty, mid_empty, bass_hit, mid_hit;
	logic [BINW-1:0] bass_wid, mid_wid;
	logic [3:0]      ch;
	logic [DVW-1:0]  bass_dvs, mid_dvs;
	logic [CNTW-1:0] len_eff;

	always_comb begin
		bass_eff = ({3'b0, cfg.bass_hi} > BINW'(FFT_BINS)) ? BINW'(FFT_BINS)
			: {3'b0, cfg.bass_hi};
		mid_eff = ({3'b0, cfg.mid_hi} > BINW'(FFT_BINS)) ? BINW'(FFT_BINS)
			: {3'b0, cfg.mid_hi};
		bass_empty = bass_eff <= {4'b0, cfg.bass_lo};
		mid_empty  = mid_eff <= {4'b0, cfg.mid_lo};
		bass_hit = ({4'b0, bin_index} >= {4'b0, cfg.bass_lo})
			&& ({4'b0, bin_index} < bass_eff);
		mid_hit = ({4'b0, bin_index} >= {4'b0, cfg.mid_lo})
			&& ({4'b0, bin_index} < mid_eff);
		bass_wid = bass_eff - {4'b0, cfg.bass_lo};
		mid_wid  = mid_eff - {4'b0, cfg.mid_lo};
		if (cfg.chan == 4'd0)
			ch = 4'd1;
		else if ({1'b0, cfg.chan} > 5'(MAX_CHANNELS))
			ch = 4'(MAX_CHANNELS);
		else
			ch = cfg.chan;
		bass_dvs = DVW'({4'b0, bass_wid[9:0]} * {10'b0, ch});
		mid_dvs  = DVW'({4'b0, mid_wid[9:0]} * {10'b0, ch});
		if (cfg.hist_len == 7'd0)
			len_eff = CNTW'(1);
		else if ({5'b0, cfg.hist_len} > 12'(HISTORY_DEPTH))
			len_eff = CNTW'(HISTORY_DEPTH);
		else
			len_eff = CNTW'(cfg.hist_len);
	end

	// band sums
	logic [SUMW-1:0] bass_sum_q, mid_sum_q;
	logic [SUMW:0]   bass_add, mid_add;

	assign bass_add = {1'b0, bass_sum_q} + (SUMW+1)'(magnitude);
	assign mid_add  = {1'b0, mid_sum_q} + (SUMW+1)'(magnitude);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bass_sum_q <= '0;
			mid_sum_q  <= '0;
		end else if (cmd.push) begin
			bass_sum_q <= '0;
			mid_sum_q  <= '0;
		end else if (in_accept) begin
			if (bass_hit)
				bass_sum_q <= bass_add[SUMW] ? sbd_pkg::SUM_MAX : bass_add[SUMW-1:0];
			if (mid_hit)
				mid_sum_q <= mid_add[SUMW] ? sbd_pkg::SUM_MAX : mid_add[SUMW-1:0];
		end
	end

	// history pointers and push
	logic [PW-1:0]   head_q;
	logic [CNTW-1:0] count_q;
	logic [CNTW-1:0] cnt_a, drop;
	logic [HW-1:0]   head_sum, tail_sum;
	logic [PW-1:0]   head_a, tail;
	logic            hist_empty;

	assign hist_empty = count_q == '0;

	always_comb begin
		if (count_q >= len_eff) begin
			cnt_a = len_eff - 1'b1;
			drop  = count_q - cnt_a;
		end else begin
			cnt_a = count_q;
			drop  = '0;
		end
		head_sum = HW'(head_q) + HW'(drop);
		head_a   = (head_sum >= HW'(HISTORY_DEPTH))
			? PW'(head_sum - HW'(HISTORY_DEPTH)) : PW'(head_sum);
		tail_sum = HW'(head_a) + HW'(cnt_a);
		tail     = (tail_sum >= HW'(HISTORY_DEPTH))
			? PW'(tail_sum - HW'(HISTORY_DEPTH)) : PW'(tail_sum);
	end

	// energies, means, variances
	logic [15:0]     be_q, me_q, meanb_q, meanm_q;
	logic [31:0]     varb_q, varm_q;

	// statistics walk
	logic [31:0]     hist_mem [HISTORY_DEPTH];
	logic            act_q, var_q, v1_s1, v2_s2, issue;
	logic [CNTW-1:0] k_q;
	logic [PW-1:0]   ptr_q;
	logic [31:0]     rd_s1;
	logic signed [16:0] db_s2, dm_s2;
	logic signed [33:0] sqb, sqm;
	logic [ACW-1:0]  accb_q, accm_q;
	logic [SQW-1:0]  sqb_q, sqm_q;
	logic            walk_done;

	assign issue     = act_q && (k_q != count_q);
	assign walk_done = act_q && (k_q == count_q) && !v1_s1 && !v2_s2;
	assign sqb       = db_s2 * db_s2;
	assign sqm       = dm_s2 * dm_s2;

	always_ff @(posedge clk) begin
		if (issue)
			rd_s1 <= hist_mem[ptr_q];
		if (cmd.push)
			hist_mem[tail] <= {me_q, be_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= 1'b0;
			var_q   <= 1'b0;
			v1_s1   <= 1'b0;
			v2_s2   <= 1'b0;
			k_q     <= '0;
			ptr_q   <= '0;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			v1_s1 <= issue;
			v2_s2 <= v1_s1 && var_q;
			if (cmd.walk_start) begin
				act_q <= 1'b1;
				var_q <= cmd.walk_var;
				k_q   <= '0;
				ptr_q <= head_q;
			end else if (walk_done) begin
				act_q <= 1'b0;
			end else if (issue) begin
				k_q   <= k_q + 1'b1;
				ptr_q <= (ptr_q == PW'(HISTORY_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
			end
			if (cmd.push) begin
				head_q  <= head_a;
				count_q <= cnt_a + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			accb_q <= '0;
			accm_q <= '0;
			sqb_q  <= '0;
			sqm_q  <= '0;
		end else begin
			if (v1_s1 && !var_q) begin
				accb_q <= accb_q + ACW'(rd_s1[15:0]);
				accm_q <= accm_q + ACW'(rd_s1[31:16]);
			end
			if (v1_s1 && var_q) begin
				db_s2 <= signed'({1'b0, rd_s1[15:0]}) - signed'({1'b0, meanb_q});
				dm_s2 <= signed'({1'b0, rd_s1[31:16]}) - signed'({1'b0, meanm_q});
			end
			if (v2_s2) begin
				sqb_q <= sqb_q + SQW'(sqb[31:0]);
				sqm_q <= sqm_q + SQW'(sqm[31:0]);
			end
		end
	end

	// shared divider
	sbd_pkg::div_sel_t sel_q;
	logic [DVDW-1:0]   dvd, quo;
	logic [DVW-1:0]    dvs;
	logic              div_done;
	logic [15:0]       quo_sat;

	always_comb begin
		case (cmd.div_sel)
			sbd_pkg::DIV_EB: begin dvd = DVDW'(bass_sum_q); dvs = bass_dvs; end
			sbd_pkg::DIV_EM: begin dvd = DVDW'(mid_sum_q);  dvs = mid_dvs;  end
			sbd_pkg::DIV_MB: begin dvd = DVDW'(accb_q); dvs = DVW'(count_q); end
			sbd_pkg::DIV_MM: begin dvd = DVDW'(accm_q); dvs = DVW'(count_q); end
			sbd_pkg::DIV_VB: begin dvd = DVDW'(sqb_q);  dvs = DVW'(count_q); end
			sbd_pkg::DIV_VM: begin dvd = DVDW'(sqm_q);  dvs = DVW'(count_q); end
			default:         begin dvd = '0; dvs = '0; end
		endcase
		quo_sat = (|quo[DVDW-1:16]) ? 16'hFFFF : quo[15:0];
	end

	sbd_div #(
		.DVD_W (DVDW),
		.DVS_W (DVW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.div_start)
			sel_q <= cmd.div_sel;
		if (div_done) begin
			case (sel_q)
				sbd_pkg::DIV_EB: be_q    <= bass_empty ? 16'd0 : quo_sat;
				sbd_pkg::DIV_EM: me_q    <= mid_empty ? 16'd0 : quo_sat;
				sbd_pkg::DIV_MB: meanb_q <= quo[15:0];
				sbd_pkg::DIV_MM: meanm_q <= quo[15:0];
				sbd_pkg::DIV_VB: varb_q  <= quo[31:0];
				sbd_pkg::DIV_VM: varm_q  <= quo[31:0];
				default: ;
			endcase
		end
	end

	// threshold and compare
	logic [35:0]        t15b, t15m;
	logic signed [21:0] thrb_raw, thrm_raw, thrb_q, thrm_q;
	logic signed [38:0] rhsb_q, rhsm_q, lhsb_q, lhsm_q;
	logic signed [16:0] eb_d, em_d;

	always_comb begin
		t15b     = {varb_q, 4'b0} - {4'b0, varb_q};
		t15m     = {varm_q, 4'b0} - {4'b0, varm_q};
		thrb_raw = sbd_pkg::THR_BASE - signed'({2'b0, t15b[35:16]});
		thrm_raw = sbd_pkg::THR_BASE - signed'({2'b0, t15m[35:16]});
		eb_d     = signed'({1'b0, be_q}) - signed'({1'b0, cfg.bass_off});
		em_d     = signed'({1'b0, me_q}) - signed'({1'b0, cfg.mid_off});
	end

	always_ff @(posedge clk) begin
		if (cmd.thr_en) begin
			thrb_q <= (thrb_raw < sbd_pkg::THR_MIN) ? sbd_pkg::THR_MIN : thrb_raw;
			thrm_q <= (thrm_raw < sbd_pkg::THR_MIN) ? sbd_pkg::THR_MIN : thrm_raw;
		end
		if (cmd.mul_en) begin
			rhsb_q <= thrb_q * signed'({1'b0, meanb_q});
			rhsm_q <= thrm_q * signed'({1'b0, meanm_q});
			lhsb_q <= 39'(signed'({eb_d, 16'b0}));
			lhsm_q <= 39'(signed'({em_d, 16'b0}));
		end
	end

	// result register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.push)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			bass_beat    <= !hist_empty && (lhsb_q > rhsb_q);
			mid_beat     <= !hist_empty && (lhsm_q > rhsm_q);
			bass_energy  <= be_q;
			mid_energy   <= me_q;
			bass_average <= hist_empty ? 16'd0 : meanb_q;
			mid_average  <= hist_empty ? 16'd0 : meanm_q;
			history_used <= 7'(count_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign st.div_done   = div_done;
	assign st.walk_done  = walk_done;
	assign st.hist_empty = hist_empty;
	assign st.out_free   = !out_valid_q || out_ready;

endmodule

// ----- sv/spectral_beat_detector_top.sv -----
`timescale 1ns / 1ps
// spectral_beat_detector_top: top level of the two-band beat detector.
// Depends on sbd_pkg, sbd_regs, sbd_ctrl, sbd_dp, sbd_div.
//
// Usage:
//  - Input channel (in_valid/in_ready): one magnitude per transaction with
//    its bin_index and frame_last. Non-last items are taken one per cycle.
//  - On a frame_last transaction the block stops taking input and runs the
//    frame-end work: two energy divisions, a walk over the history for the
//    means, two mean divisions, a second walk for the variances, two
//    variance divisions, then the threshold and multiply steps; the compare
//    is made when the result is pushed. All divisions use the single shared
//    serial divider. With an empty history everything after the energy
//    divisions is skipped up to the push. Input is ready again once the
//    result is pushed.
//  - Output channel (out_valid/out_ready): one result transaction per frame,
//    held in an output register; new bins are taken while it waits. If the
//    receiver stalls, the next frame end waits before pushing its result.
//  - APB port: registers at byte address 4*i, pready always high.
//  - Reset (arst_n low) clears sums, history count and head, and loads the
//    register defaults; the history memory needs no clearing.
module spectral_beat_detector_top #(
	parameter int unsigned HISTORY_DEPTH = sbd_pkg::HISTORY_DEPTH_DEF,
	parameter int unsigned FFT_BINS      = sbd_pkg::FFT_BINS_DEF,
	parameter int unsigned MAX_CHANNELS  = sbd_pkg::MAX_CHANNELS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sbd_pkg::APB_AW-1:0] paddr,
	input  logic [sbd_pkg::APB_DW-1:0] pwdata,
	output logic [sbd_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [8:0]                 bin_index,
	input  logic [15:0]                magnitude,
	input  logic                       frame_last,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       bass_beat,
	output logic                       mid_beat,
	output logic [15:0]                bass_energy,
	output logic [15:0]                mid_energy,
	output logic [15:0]                bass_average,
	output logic [15:0]                mid_average,
	output logic [6:0]                 history_used
);

	sbd_pkg::cfg_t  cfg;
	sbd_pkg::cmd_t  cmd;
	sbd_pkg::stat_t st;
	logic           in_accept;

	assign in_accept = in_valid & in_ready;

	sbd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sbd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_accept  (in_accept),
		.frame_last (frame_last),
		.st         (st),
		.cmd        (cmd),
		.in_ready   (in_ready)
	);

	sbd_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.FFT_BINS      (FFT_BINS),
		.MAX_CHANNELS  (MAX_CHANNELS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.st           (st),
		.in_accept    (in_accept),
		.bin_index    (bin_index),
		.magnitude    (magnitude),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bass_beat    (bass_beat),
		.mid_beat     (mid_beat),
		.bass_energy  (bass_energy),
		.mid_energy   (mid_energy),
		.bass_average (bass_average),
		.mid_average  (mid_average),
		.history_used (history_used)
	);

endmodule
